[design/ler_pkg.sv]
package ler_pkg;

    // Fixed field widths of the command and result transactions
    localparam int unsigned EVENT_FIELD_W = 64;
    localparam int unsigned POS_W         = 32;
    localparam int unsigned BUDGET_W      = 7;

    // Largest number of results one read or peek may produce
    localparam logic [BUDGET_W-1:0] MAX_RUN = 7'd64;

    // Command codes
    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_READ = 2'd1;
    localparam logic [1:0] CMD_PEEK = 2'd2;

    typedef struct packed {
        logic [1:0]               command;
        logic [EVENT_FIELD_W-1:0] event_word;
        logic [POS_W-1:0]         reader_cursor;
        logic [BUDGET_W-1:0]      max_events;
    } t_in_item;

    typedef struct packed {
        logic                     has_event;
        logic [EVENT_FIELD_W-1:0] event_out;
        logic [POS_W-1:0]         next_cursor;
        logic [POS_W-1:0]         dropped_count;
        logic [POS_W-1:0]         oldest_position;
        logic                     last_of_run;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_EMIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic do_push;
        logic load_run;
        logic mod_step;
        logic emit_event;
        logic emit_empty;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic mod_done;
        logic run_empty;
        logic run_last;
    } t_dp_status;

endpackage

[design/ler_ram.sv]
module ler_ram
    import ler_pkg::*;
#(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/ler_ctrl.sv]
module ler_ctrl
    import ler_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_command,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_busy
);

    t_state r_state;
    t_state n_state;
    logic   accept;
    logic   is_run;

    assign accept = i_start && (r_state == ST_IDLE);
    assign is_run = (i_command == CMD_READ) || (i_command == CMD_PEEK);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && is_run) begin
                    n_state = ST_MOD;
                end
            end
            ST_MOD: begin
                if (i_status.mod_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.run_empty || i_status.run_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath commands
    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.do_push  = accept && (i_command == CMD_PUSH);
                o_cmd.load_run = accept && is_run;
            end
            ST_MOD: begin
                o_cmd.mod_step = !i_status.mod_done;
            end
            ST_EMIT: begin
                o_cmd.emit_empty = i_status.run_empty;
                o_cmd.emit_event = !i_status.run_empty;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

    // Only one kind of result can be issued in a cycle
    a_one_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.emit_event && o_cmd.emit_empty))
        else $error("event and empty result issued together");

    // An empty run ends the command at once
    a_empty_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit_empty |=> (r_state == ST_IDLE))
        else $error("empty result did not end the run");

endmodule

[design/ler_datapath.sv]
module ler_datapath
    import ler_pkg::*;
#(
    parameter int RING_DEPTH = 4096,
    parameter int EVENT_BITS = 64,
    parameter int PEEK_LIMIT = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_item   i_item,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output logic       o_strobe,
    output t_out_item  o_result
);

    localparam int SW       = $clog2(RING_DEPTH);
    localparam int PROD_W   = 2 * POS_W;
    localparam bit IS_POW2  = ((RING_DEPTH & (RING_DEPTH - 1)) == 0);
    localparam logic [SW-1:0]    SLOT_LAST = SW'(RING_DEPTH - 1);
    localparam logic [POS_W-1:0] DEPTH_POS = POS_W'(RING_DEPTH);
    localparam logic [POS_W-1:0] PEEK_POS  = POS_W'(PEEK_LIMIT);
    // floor(2^32 / depth); the estimated quotient is low by at most one
    localparam logic [POS_W-1:0] RECIP     = POS_W'(64'h1_0000_0000 / RING_DEPTH);

    // Ring counters
    logic [POS_W-1:0] r_wr_cnt;
    logic [POS_W-1:0] r_old_cnt;
    logic [SW-1:0]    r_wr_slot;

    // Run state
    logic [POS_W-1:0]    r_cur;
    logic [POS_W-1:0]    r_drop;
    logic [BUDGET_W-1:0] r_budget;
    logic [BUDGET_W-1:0] r_cnt;
    logic [SW-1:0]       r_slot;

    // Reciprocal remainder unit
    logic [1:0]        r_mod_cnt;
    logic [PROD_W-1:0] r_mod_prod;
    logic [POS_W-1:0]  r_mod_qd;
    logic [POS_W-1:0]  mod_diff;
    logic [POS_W-1:0]  mod_wrap;
    logic [SW-1:0]     mod_slot;

    // Result stage
    logic             r_p_valid;
    logic             r_p_has;
    logic [POS_W-1:0] r_p_cursor;
    logic [POS_W-1:0] r_p_drop;
    logic [POS_W-1:0] r_p_old;
    logic             r_p_last;

    logic [EVENT_BITS-1:0] ram_q;

    // Run setup terms
    logic [POS_W-1:0]    wr_inc;
    logic [POS_W-1:0]    cur_lag;
    logic                lapped;
    logic [POS_W-1:0]    avail;
    logic [POS_W-1:0]    show;
    logic [POS_W-1:0]    start_cur;
    logic [POS_W-1:0]    start_drop;
    logic [BUDGET_W-1:0] budget_sat;
    logic                is_read;

    // Emission terms
    logic [POS_W-1:0]    cur_inc;
    logic [BUDGET_W-1:0] cnt_inc;
    logic                run_last;
    logic [SW-1:0]       slot_inc;

    assign wr_inc     = r_wr_cnt + 32'd1;
    assign is_read    = (i_item.command == CMD_READ);
    assign cur_lag    = i_item.reader_cursor - r_old_cnt;
    assign lapped     = cur_lag > DEPTH_POS;
    assign avail      = r_wr_cnt - r_old_cnt;
    assign show       = (avail < PEEK_POS) ? avail : PEEK_POS;
    assign budget_sat = (i_item.max_events > MAX_RUN) ? MAX_RUN : i_item.max_events;

    // Pick the starting cursor and drop count for a read or peek
    always_comb begin
        if (is_read) begin
            start_cur  = lapped ? r_old_cnt : i_item.reader_cursor;
            start_drop = lapped ? (r_old_cnt - i_item.reader_cursor) : '0;
        end else begin
            start_cur  = r_wr_cnt - show;
            start_drop = '0;
        end
    end

    // Final remainder step: the partial remainder is below twice the depth
    assign mod_diff = r_cur - r_mod_qd;
    assign mod_wrap = mod_diff - DEPTH_POS;
    assign mod_slot = (mod_diff >= DEPTH_POS) ? mod_wrap[SW-1:0] : mod_diff[SW-1:0];

    assign cur_inc  = r_cur + 32'd1;
    assign cnt_inc  = r_cnt + 7'd1;
    assign run_last = (cur_inc == r_wr_cnt) || (cnt_inc >= r_budget);
    assign slot_inc = ((cur_inc == '0) || (r_slot == SLOT_LAST)) ? '0 : (r_slot + SW'(1));

    assign o_status.mod_done  = IS_POW2 || (r_mod_cnt == 2'd3);
    assign o_status.run_empty = (r_cur == r_wr_cnt) || (r_budget == '0);
    assign o_status.run_last  = run_last;

    // Advance the head on a push, and the tail too when the ring would overflow
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_cnt  <= '0;
            r_old_cnt <= '0;
            r_wr_slot <= '0;
        end else if (i_cmd.do_push) begin
            r_wr_cnt  <= wr_inc;
            r_wr_slot <= ((wr_inc == '0) || (r_wr_slot == SLOT_LAST)) ? '0
                                                                       : (r_wr_slot + SW'(1));
            if ((wr_inc - r_old_cnt) > DEPTH_POS) begin
                r_old_cnt <= r_old_cnt + 32'd1;
            end
        end
    end

    // Remainder step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod_cnt <= '0;
        end else if (i_cmd.load_run) begin
            r_mod_cnt <= '0;
        end else if (i_cmd.mod_step) begin
            r_mod_cnt <= r_mod_cnt + 2'd1;
        end
    end

    // Multiply by the reciprocal, then multiply the quotient back by the depth
    always_ff @(posedge i_clk) begin
        if (i_cmd.mod_step) begin
            if (r_mod_cnt == 2'd0) begin
                r_mod_prod <= PROD_W'(r_cur) * PROD_W'(RECIP);
            end else if (r_mod_cnt == 2'd1) begin
                r_mod_qd <= r_mod_prod[PROD_W-1:POS_W] * DEPTH_POS;
            end
        end
    end

    // Load, reduce and walk the run cursor
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_run) begin
            r_cur    <= start_cur;
            r_drop   <= start_drop;
            r_budget <= budget_sat;
            r_cnt    <= '0;
            r_slot   <= start_cur[SW-1:0];
        end else if (i_cmd.mod_step) begin
            if (r_mod_cnt == 2'd2) begin
                r_slot <= mod_slot;
            end
        end else if (i_cmd.emit_event) begin
            r_cur  <= cur_inc;
            r_cnt  <= cnt_inc;
            r_slot <= slot_inc;
        end
    end

    // Result stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= i_cmd.emit_event || i_cmd.emit_empty;
        end
    end

    // Result stage metadata
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_event) begin
            r_p_has    <= 1'b1;
            r_p_cursor <= cur_inc;
            r_p_drop   <= (r_cnt == '0) ? r_drop : '0;
            r_p_last   <= run_last;
            r_p_old    <= r_old_cnt;
        end else if (i_cmd.emit_empty) begin
            r_p_has    <= 1'b0;
            r_p_cursor <= r_cur;
            r_p_drop   <= r_drop;
            r_p_last   <= 1'b1;
            r_p_old    <= r_old_cnt;
        end
    end

    ler_ram #(
        .WIDTH (EVENT_BITS),
        .DEPTH (RING_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.do_push),
        .i_wr_addr (r_wr_slot),
        .i_wr_data (i_item.event_word[EVENT_BITS-1:0]),
        .i_rd_en   (i_cmd.emit_event),
        .i_rd_addr (r_slot),
        .o_rd_data (ram_q)
    );

    // Drive the result transaction
    assign o_strobe                 = r_p_valid;
    assign o_result.has_event       = r_p_has;
    assign o_result.event_out       = r_p_has ? EVENT_FIELD_W'(ram_q) : '0;
    assign o_result.next_cursor     = r_p_cursor;
    assign o_result.dropped_count   = r_p_drop;
    assign o_result.oldest_position = r_p_old;
    assign o_result.last_of_run     = r_p_last;

    // Ring never holds more than its depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_cnt - r_old_cnt) <= DEPTH_POS)
        else $error("ring fill exceeds depth");

    // A result without an event always closes its command
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p_valid && !r_p_has) |-> r_p_last)
        else $error("empty result not marked last");

    // Results of one command come in consecutive cycles
    a_run_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p_valid && !r_p_last) |=> r_p_valid)
        else $error("gap inside a result run");

    // No push lands while a run is walking the ring
    a_no_push_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_event |-> !i_cmd.do_push)
        else $error("push during emission");

endmodule

[design/lossy_event_ring_with_cursors.sv]
// Lossy event ring with per-reader cursors. A push (command 0) keeps
// busy low, and a push may be issued in every cycle while the block is idle.
// A read or peek occupies the block until its run ends and gives at least
// one result. When RING_DEPTH is not a power of two, a reciprocal-multiply
// remainder unit first turns the 32-bit start cursor into a ring slot; for
// a power of two the low cursor bits are the slot. Results come out one per
// cycle on o_strobe, in the cycle after each read of the registered event
// store, with no gaps inside a run; the last carries last_of_run. The
// receiver cannot stall, so it must take every strobed transaction.
module lossy_event_ring_with_cursors
    import ler_pkg::*;
#(
    parameter int RING_DEPTH = 4096,
    parameter int EVENT_BITS = 64,
    parameter int PEEK_LIMIT = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_in_item  i_item,
    output logic      o_busy,
    output logic      o_strobe,
    output t_out_item o_result
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    ler_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .i_command (i_item.command),
        .i_status  (dp_status),
        .o_cmd     (dp_cmd),
        .o_busy    (o_busy)
    );

    ler_datapath #(
        .RING_DEPTH (RING_DEPTH),
        .EVENT_BITS (EVENT_BITS),
        .PEEK_LIMIT (PEEK_LIMIT)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (dp_cmd),
        .o_status (dp_status),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule
